### design/mvt_pkg.sv
// types, constants and codes shared by the matrix-vector transform block
// no dependencies; imported by every module of the block
package mvt_pkg;

  localparam int MAX_DIM   = 4;
  localparam int FRAC_BITS = 16;
  localparam int ELEM_W    = 32;
  localparam int DIM_W     = 3;
  localparam int ROW_W     = 2;
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int SUM_W     = PROD_W + $clog2(MAX_DIM);
  localparam int SH_W      = SUM_W - FRAC_BITS;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);
  localparam logic [DIM_W-1:0] DIM_MIN   = DIM_W'(2);

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_XFORM = 1'b1
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic [ROW_W-1:0]         row_index;
    logic signed [ELEM_W-1:0] elem0;
    logic signed [ELEM_W-1:0] elem1;
    logic signed [ELEM_W-1:0] elem2;
    logic signed [ELEM_W-1:0] elem3;
  } in_item_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] res0;
    logic signed [ELEM_W-1:0] res1;
    logic signed [ELEM_W-1:0] res2;
    logic signed [ELEM_W-1:0] res3;
  } out_item_t;

  // classified item passed from front to back
  typedef struct packed {
    logic                           is_load;
    logic [ROW_W-1:0]               row;
    logic [MAX_DIM-1:0]             lane_en;
    logic [MAX_DIM-1:0][ELEM_W-1:0] vec;
  } q_item_t;

  typedef struct packed {
    logic               full;
    logic               empty;
    logic [Q_CNT_W-1:0] count;
  } q_status_t;

endpackage

### design/mvt_front.sv
// front end: accepts input items, classifies load or transform, masks unused lanes
// depends on mvt_pkg
module mvt_front import mvt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [DIM_W-1:0] dim,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             f_valid,
  input  logic             f_ready,
  output q_item_t          f_item
);

  logic               fv_r;
  logic               fv_nxt;
  q_item_t            item_r;
  q_item_t            item_nxt;
  logic [DIM_W-1:0]   eff_dim;
  logic [MAX_DIM-1:0] lane_en;

  always_comb begin
    if (dim < DIM_MIN) begin
      eff_dim = DIM_MIN;
    end else if (dim > DIM_W'(MAX_DIM)) begin
      eff_dim = DIM_W'(MAX_DIM);
    end else begin
      eff_dim = dim;
    end
    for (int c = 0; c < MAX_DIM; c++) begin
      lane_en[c] = DIM_W'(c) < eff_dim;
    end
  end

  assign in_ready = !fv_r || f_ready;

  always_comb begin
    item_nxt.is_load = (in_data.op == OP_LOAD);
    item_nxt.row     = in_data.row_index;
    item_nxt.lane_en = lane_en;
    item_nxt.vec[0]  = in_data.elem0;
    item_nxt.vec[1]  = in_data.elem1;
    item_nxt.vec[2]  = in_data.elem2;
    item_nxt.vec[3]  = in_data.elem3;
    // a transform ignores vector elements beyond the dimension; a load keeps the full row
    if (in_data.op == OP_XFORM) begin
      for (int c = 0; c < MAX_DIM; c++) begin
        if (!lane_en[c]) begin
          item_nxt.vec[c] = '0;
        end
      end
    end
  end

  always_comb begin
    fv_nxt = fv_r;
    if (in_ready) begin
      fv_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= item_nxt;
    end
  end

  assign f_valid = fv_r;
  assign f_item  = item_r;

endmodule

### design/mvt_queue.sv
// short fifo of classified items between front and back
// depends on mvt_pkg
module mvt_queue import mvt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  q_item_t   push_item,
  output logic      pop_valid,
  input  logic      pop_ready,
  output q_item_t   pop_item,
  output q_status_t status
);

  q_item_t            mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r;
  logic [Q_CNT_W-1:0] count_nxt;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count_r != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign status.full  = !push_ready;
  assign status.empty = !pop_valid;
  assign status.count = count_r;

endmodule

### design/mvt_back.sv
// back end: holds the matrix, applies row loads, runs the multiply / sum / saturate pipe
// depends on mvt_pkg
module mvt_back import mvt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  output logic      q_ready,
  input  q_item_t   q_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic signed [ELEM_W-1:0] matrix_r [MAX_DIM][MAX_DIM];

  logic                     s1_v_r;
  logic                     s1_v_nxt;
  logic [MAX_DIM-1:0]       s1_en_r;
  logic signed [PROD_W-1:0] s1_prod_r [MAX_DIM][MAX_DIM];

  logic                     s2_v_r;
  logic                     s2_v_nxt;
  logic [MAX_DIM-1:0]       s2_en_r;
  logic signed [SUM_W-1:0]  s2_sum_r [MAX_DIM];
  logic signed [SUM_W-1:0]  sum_nxt [MAX_DIM];

  logic                     s3_v_r;
  logic                     s3_v_nxt;
  out_item_t                out_r;
  logic [ELEM_W-1:0]        res_nxt [MAX_DIM];

  logic                     s1_free;
  logic                     s2_free;
  logic                     s3_free;
  logic                     pop;
  logic                     load_go;
  logic                     xform_go;

  // each stage advances when it or a later stage has room, so bubbles are squeezed out
  assign s3_free  = !s3_v_r || out_ready;
  assign s2_free  = !s2_v_r || s3_free;
  assign s1_free  = !s1_v_r || s2_free;

  assign q_ready  = q_item.is_load || s1_free;
  assign pop      = q_valid && q_ready;
  assign load_go  = pop && q_item.is_load;
  assign xform_go = pop && !q_item.is_load;

  // matrix write takes effect after earlier transforms have sampled it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < MAX_DIM; r++) begin
        for (int c = 0; c < MAX_DIM; c++) begin
          matrix_r[r][c] <= '0;
        end
      end
    end else if (load_go) begin
      for (int c = 0; c < MAX_DIM; c++) begin
        matrix_r[q_item.row][c] <= $signed(q_item.vec[c]);
      end
    end
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    s2_v_nxt = s2_v_r;
    s3_v_nxt = s3_v_r;
    if (s1_free) begin
      s1_v_nxt = xform_go;
    end
    if (s2_free) begin
      s2_v_nxt = s1_v_r;
    end
    if (s3_free) begin
      s3_v_nxt = s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
      s3_v_r <= s3_v_nxt;
    end
  end

  // stage 1: sixteen exact products
  always_ff @(posedge clk) begin
    if (xform_go && s1_free) begin
      s1_en_r <= q_item.lane_en;
      for (int r = 0; r < MAX_DIM; r++) begin
        for (int c = 0; c < MAX_DIM; c++) begin
          s1_prod_r[r][c] <= PROD_W'(matrix_r[r][c] * $signed(q_item.vec[c]));
        end
      end
    end
  end

  // stage 2: exact row sums
  always_comb begin
    for (int r = 0; r < MAX_DIM; r++) begin
      sum_nxt[r] = '0;
      for (int c = 0; c < MAX_DIM; c++) begin
        sum_nxt[r] = sum_nxt[r] + SUM_W'(s1_prod_r[r][c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r && s2_free) begin
      s2_en_r <= s1_en_r;
      for (int r = 0; r < MAX_DIM; r++) begin
        s2_sum_r[r] <= sum_nxt[r];
      end
    end
  end

  // stage 3: floor shift, saturate, zero unused rows
  always_comb begin
    logic signed [SH_W-1:0] sh;
    sh = '0;
    for (int r = 0; r < MAX_DIM; r++) begin
      sh = SH_W'(s2_sum_r[r] >>> FRAC_BITS);
      if (!s2_en_r[r]) begin
        res_nxt[r] = '0;
      end else if (sh[SH_W-1:ELEM_W-1] != {(SH_W-ELEM_W+1){sh[SH_W-1]}}) begin
        res_nxt[r] = sh[SH_W-1] ? {1'b1, {(ELEM_W-1){1'b0}}} : {1'b0, {(ELEM_W-1){1'b1}}};
      end else begin
        res_nxt[r] = sh[ELEM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r && s3_free) begin
      out_r.res0 <= $signed(res_nxt[0]);
      out_r.res1 <= $signed(res_nxt[1]);
      out_r.res2 <= $signed(res_nxt[2]);
      out_r.res3 <= $signed(res_nxt[3]);
    end
  end

  assign out_valid = s3_v_r;
  assign out_data  = out_r;

endmodule

### design/matrix_vector_transform_4x4.sv
// matrix_vector_transform_4x4: 4x4 signed Q16.16 matrix times vector, saturated
// throughput: one item per cycle, loads and transforms alike, while out_ready does not
// hold back the pipe, through four parallel row dot products; a transform passes the front
// register, queue, product stage, sum stage and output register before out_valid rises
// reset: synchronous active-low rst_n clears the matrix to zero, dimension to 4
module matrix_vector_transform_4x4 import mvt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [DIM_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data
);

  logic [DIM_W-1:0] dim_r;
  logic [DIM_W-1:0] dim_nxt;
  logic             f_valid;
  logic             f_ready;
  q_item_t          f_item;
  logic             q_valid;
  logic             q_ready;
  q_item_t          q_item;
  q_status_t        q_stat;

  assign dim_nxt = cfg_wr_en ? cfg_wr_data : dim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= DIM_RESET;
    end else begin
      dim_r <= dim_nxt;
    end
  end

  mvt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .dim      (dim_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .f_valid  (f_valid),
    .f_ready  (f_ready),
    .f_item   (f_item)
  );

  mvt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item),
    .status     (q_stat)
  );

  mvt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // queue occupancy stays within its depth and steps by at most one per cycle
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count beyond depth");

  a_q_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (q_stat.count == $past(q_stat.count) ||
                      q_stat.count == $past(q_stat.count) + 1'b1 ||
                      q_stat.count == $past(q_stat.count) - 1'b1))
    else $error("queue count jumped");

  // unused result rows are zero under a small dimension
  a_row3_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && dim_r < DIM_W'(MAX_DIM) |-> out_data.res3 == '0)
    else $error("row 3 not zeroed");

  a_row2_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && dim_r < DIM_W'(3) |-> out_data.res2 == '0)
    else $error("row 2 not zeroed");

endmodule

### tb/mvt_checker.sv
`timescale 1ns / 100ps
// scoreboard for matrix_vector_transform_4x4: tracks the matrix and dimension, predicts
// each transform result and compares the result channel against it; depends on mvt_pkg
module mvt_checker import mvt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [DIM_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  input  logic             in_ready,
  input  in_item_t         in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  out_item_t        out_data,
  output int               fail_count,
  output int               pending,
  output int               checked
);

  logic signed [ELEM_W-1:0] mat_rows [MAX_DIM][MAX_DIM];
  logic [DIM_W-1:0]         dim_reg;
  out_item_t                result_q [$];
  int                       errors;
  int                       n_checked;

  assign fail_count = errors;
  assign checked    = n_checked;

  initial begin
    errors    = 0;
    n_checked = 0;
    pending   = 0;
  end

  // rows dot vector at full width, floor shift, saturate to 32 bits
  function automatic out_item_t transform_vec(in_item_t it);
    logic signed [ELEM_W-1:0]   vec [MAX_DIM];
    logic signed [ELEM_W-1:0]   res [MAX_DIM];
    logic signed [PROD_W+1:0]   acc;
    logic signed [PROD_W+1:0]   shifted;
    int                         d;
    out_item_t                  r;
    vec[0] = it.elem0;
    vec[1] = it.elem1;
    vec[2] = it.elem2;
    vec[3] = it.elem3;
    d = int'(dim_reg);
    if (d < 2) d = 2;
    if (d > MAX_DIM) d = MAX_DIM;
    for (int row = 0; row < MAX_DIM; row++) begin
      res[row] = '0;
      if (row < d) begin
        acc = '0;
        for (int c = 0; c < d; c++) begin
          acc = acc + mat_rows[row][c] * vec[c];
        end
        shifted = acc >>> FRAC_BITS;
        if (shifted > $signed({{(PROD_W-ELEM_W+2){1'b0}}, 1'b0, {(ELEM_W-1){1'b1}}}))
          res[row] = {1'b0, {(ELEM_W-1){1'b1}}};
        else if (shifted < $signed({{(PROD_W-ELEM_W+2){1'b1}}, 1'b1, {(ELEM_W-1){1'b0}}}))
          res[row] = {1'b1, {(ELEM_W-1){1'b0}}};
        else
          res[row] = shifted[ELEM_W-1:0];
      end
    end
    r.res0 = res[0];
    r.res1 = res[1];
    r.res2 = res[2];
    r.res3 = res[3];
    return r;
  endfunction

  task automatic check_field(string name, logic signed [ELEM_W-1:0] exp_v,
                             logic signed [ELEM_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t exp_item;
    if (!rst_n) begin
      for (int r = 0; r < MAX_DIM; r++)
        for (int c = 0; c < MAX_DIM; c++)
          mat_rows[r][c] = '0;
      dim_reg = DIM_RESET;
      result_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("result transfer with nothing expected: res0 %0d", out_data.res0);
          errors++;
        end else begin
          exp_item = result_q.pop_front();
          check_field("res0", exp_item.res0, out_data.res0);
          check_field("res1", exp_item.res1, out_data.res1);
          check_field("res2", exp_item.res2, out_data.res2);
          check_field("res3", exp_item.res3, out_data.res3);
          n_checked++;
        end
      end
      if (in_valid && in_ready) begin
        if (in_data.op == OP_LOAD) begin
          mat_rows[in_data.row_index][0] = in_data.elem0;
          mat_rows[in_data.row_index][1] = in_data.elem1;
          mat_rows[in_data.row_index][2] = in_data.elem2;
          mat_rows[in_data.row_index][3] = in_data.elem3;
        end else begin
          result_q.push_back(transform_vec(in_data));
        end
      end
      // register write takes effect for transfers after this edge
      if (cfg_wr_en) dim_reg = cfg_wr_data;
    end
    pending <= result_q.size();
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// top of the matrix_vector_transform_4x4 bench: clock, reset, stimulus and verdict;
// depends on mvt_pkg, the block itself and mvt_checker
module testbench import mvt_pkg::*; ();

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 10;
  localparam int PHASE_ITEMS  = 176;

  localparam logic signed [ELEM_W-1:0] Q_MIN = {1'b1, {(ELEM_W-1){1'b0}}};
  localparam logic signed [ELEM_W-1:0] Q_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic signed [ELEM_W-1:0] Q_ONE = ELEM_W'(1) << FRAC_BITS;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [DIM_W-1:0] cfg_wr_data;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_ready;
  out_item_t        out_data;
  logic             idle_on;

  int fail_count;
  int pending;
  int checked;
  int cycles;
  int n_sent;
  int n_dims;

  matrix_vector_transform_4x4 dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  mvt_checker scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= idle_on ? ($urandom_range(99) >= 29) : 1'b1;
  end

  function automatic logic signed [ELEM_W-1:0] rand_elem();
    case ($urandom_range(9))
      0:       return Q_MIN;
      1:       return Q_MAX;
      2, 3, 4: return $urandom;
      default: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  function automatic in_item_t make_item(op_t op, logic [ROW_W-1:0] row,
                                         logic signed [ELEM_W-1:0] e0,
                                         logic signed [ELEM_W-1:0] e1,
                                         logic signed [ELEM_W-1:0] e2,
                                         logic signed [ELEM_W-1:0] e3);
    in_item_t it;
    it.op        = op;
    it.row_index = row;
    it.elem0     = e0;
    it.elem1     = e1;
    it.elem2     = e2;
    it.elem3     = e3;
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    gap = 0;
    if (idle_on) begin
      while ($urandom_range(99) < 29) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  // hold off the sender until every expected result is out and the pipe is empty
  task automatic drain();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_dim(logic [DIM_W-1:0] d);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= d;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    n_dims++;
  endtask

  task automatic send_directed();
    send_item(make_item(OP_LOAD, 2'd0, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
    send_item(make_item(OP_LOAD, 2'd1, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
    send_item(make_item(OP_LOAD, 2'd2, Q_ONE, -Q_ONE, 32'sd1, -32'sd1));
    send_item(make_item(OP_LOAD, 2'd3, Q_MIN, Q_MAX, 32'sd0, Q_ONE));
    send_item(make_item(OP_XFORM, 2'd3, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
    send_item(make_item(OP_XFORM, 2'd0, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
    send_item(make_item(OP_XFORM, 2'd1, Q_ONE, Q_ONE, Q_ONE, Q_ONE));
    // -1 lsb products exercise the floor shift
    send_item(make_item(OP_XFORM, 2'd2, -32'sd1, -32'sd1, -32'sd1, -32'sd1));
    send_item(make_item(OP_XFORM, 2'd0, 32'sd1, 32'sd0, 32'sd0, 32'sd0));
    send_item(make_item(OP_XFORM, 2'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0));
    send_item(make_item(OP_XFORM, 2'd3, Q_MIN, Q_MAX, -32'sd1, 32'sd1));
    // identity, loaded back to back with the transform that uses it
    send_item(make_item(OP_LOAD, 2'd0, Q_ONE, 32'sd0, 32'sd0, 32'sd0));
    send_item(make_item(OP_LOAD, 2'd1, 32'sd0, Q_ONE, 32'sd0, 32'sd0));
    send_item(make_item(OP_LOAD, 2'd2, 32'sd0, 32'sd0, Q_ONE, 32'sd0));
    send_item(make_item(OP_LOAD, 2'd3, 32'sd0, 32'sd0, 32'sd0, Q_ONE));
    send_item(make_item(OP_XFORM, 2'd1, Q_MIN, Q_MAX, -Q_ONE, 32'sh1234_5678));
    send_item(make_item(OP_XFORM, 2'd2, rand_elem(), rand_elem(), rand_elem(), rand_elem()));
  endtask

  task automatic send_random(int count, bit mid_pause);
    op_t op;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(99) < 30) ? OP_LOAD : OP_XFORM;
      send_item(make_item(op, ROW_W'($urandom), rand_elem(), rand_elem(),
                          rand_elem(), rand_elem()));
      if (mid_pause && i == count / 2) drain();
    end
  endtask

  logic [DIM_W-1:0] dim_seq [9] = '{3'd2, 3'd3, 3'd4, 3'd0, 3'd1, 3'd7, 3'd5, 3'd6, 3'd4};

  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_ready   = 1'b0;
    idle_on     = 1'b1;
    cycles      = 0;
    n_sent      = 0;
    n_dims      = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_dim(DIM_RESET);
    send_directed();
    drain();
    foreach (dim_seq[p]) begin
      write_dim(dim_seq[p]);
      // one phase with both sides streaming back to back
      idle_on <= (p != 2);
      send_random(PHASE_ITEMS, p == 0);
      drain();
    end
    $display("tb: %0d input transfers, %0d results checked, %0d dimension writes (0..7)",
             n_sent, checked, n_dims);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
